// ===== design/gsi_pkg.sv =====
// Shared types, sizes and codes for the gapped sequence insert block.
// No dependencies; every other design file refers to this package by scoped names.
package gsi_pkg;

    localparam int SLOTS      = 1024;
    localparam int VALUE_BITS = 16;

    localparam int POS_W   = 11;
    localparam int DATA_W  = 16;
    localparam int LEN_W   = 11;
    localparam int IDX_W   = (SLOTS > 2) ? $clog2(SLOTS) : 1;
    localparam int HM_W    = IDX_W + 1;

    // Cells are summarized in groups of GROUP for the hole search and the read select
    localparam int GROUP   = 32;
    localparam int LIDX_W  = $clog2(GROUP);
    localparam int NGROUPS = (SLOTS + GROUP - 1) / GROUP;
    localparam int GIDX_W  = (NGROUPS > 1) ? $clog2(NGROUPS) : 1;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_READ   = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_GROUP,
        ST_SCAN,
        ST_APPLY
    } gsi_state_t;

    // Broadcast to every cell on the apply cycle
    typedef struct packed {
        logic                  apply;
        logic [IDX_W-1:0]      start;
        logic [IDX_W-1:0]      hole;
        logic [VALUE_BITS-1:0] value;
    } gsi_shift_t;

    // Registered summary of one group of cells
    typedef struct packed {
        logic                  found;
        logic [LIDX_W-1:0]     first;
        logic                  rused;
        logic [VALUE_BITS-1:0] rdata;
    } gsi_grp_t;

endpackage

// ===== design/gsi_cell.sv =====
// One slot of the row: a value and an occupied mark, loaded from the left neighbor on a shift.
// Depends on gsi_pkg.
module gsi_cell (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [gsi_pkg::IDX_W-1:0]     my_idx,
    input  gsi_pkg::gsi_shift_t           cmd,
    input  logic [gsi_pkg::VALUE_BITS-1:0] left_value,
    input  logic                          left_used,
    output logic [gsi_pkg::VALUE_BITS-1:0] value_q,
    output logic                          used_q
);

    logic [gsi_pkg::VALUE_BITS-1:0] value_reg;
    logic [gsi_pkg::VALUE_BITS-1:0] value_next;
    logic                           used_reg;
    logic                           used_next;

    always_comb begin
        value_next = value_reg;
        used_next  = used_reg;
        if (cmd.apply) begin
            if (my_idx == cmd.start) begin
                value_next = cmd.value;
                used_next  = 1'b1;
            end else if ((my_idx > cmd.start) && (my_idx <= cmd.hole)) begin
                // take the neighbor's slot: one step right
                value_next = left_value;
                used_next  = left_used;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg <= 1'b0;
        end else begin
            used_reg <= used_next;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    assign value_q = value_reg;
    assign used_q  = used_reg;

endmodule

// ===== design/gsi_group.sv =====
// Summary of one group of cells: first free slot at or after the start index, and read select.
// Depends on gsi_pkg.
module gsi_group (
    input  logic                           aclk,
    input  logic [gsi_pkg::GIDX_W-1:0]     gnum,
    input  logic [gsi_pkg::IDX_W-1:0]      start,
    input  logic [gsi_pkg::GROUP-1:0]      used,
    input  logic [gsi_pkg::VALUE_BITS-1:0] value [gsi_pkg::GROUP],
    output gsi_pkg::gsi_grp_t              summary
);

    gsi_pkg::gsi_grp_t          sum_next;
    gsi_pkg::gsi_grp_t          sum_reg;
    logic [gsi_pkg::LIDX_W-1:0] local_idx;
    logic                       sel;

    assign local_idx = gsi_pkg::LIDX_W'(start);
    assign sel       = ((32'(start) >> gsi_pkg::LIDX_W) == 32'(gnum));

    always_comb begin
        sum_next.found = 1'b0;
        sum_next.first = '0;
        // lowest free cell whose index is not below start wins
        for (int j = gsi_pkg::GROUP - 1; j >= 0; j--) begin
            if (!used[j] &&
                (((32'(gnum) << gsi_pkg::LIDX_W) + 32'(j)) >= 32'(start))) begin
                sum_next.found = 1'b1;
                sum_next.first = gsi_pkg::LIDX_W'(j);
            end
        end
        sum_next.rused = sel && used[local_idx];
        sum_next.rdata = sum_next.rused ? value[local_idx] : '0;
    end

    always_ff @(posedge aclk) begin
        sum_reg <= sum_next;
    end

    assign summary = sum_reg;

endmodule

// ===== design/gapped_sequence_insert.sv =====
// Top level of the gapped sequence insert block: control sequencer, row of slot cells,
// group summaries and result register. Depends on gsi_pkg, gsi_cell and gsi_group.
//
//   channel   direction  handshake          payload
//   s_*       in         s_valid / s_ready  s_kind, s_position, s_value
//   m_*       out        m_valid / m_ready  m_read_value, m_read_used, m_length, m_full_res
//   cfg_*     in         cfg_wr_en          cfg_wr_data (min_length)
//
// Each item passes through accept, group summary, scan over the group summaries and apply;
// the apply step waits while the result register is full. The scan runs through GROUP-wide
// and then NGROUPS-wide priority encoders. One item is in work at a time.
// Synchronous active-low reset clears every occupied mark, the high mark and min_length;
// slot values need no clearing since a free slot reads as zero.
// A result waiting in the output register does not block the next item's accept;
// the apply step holds until the register frees up.
module gapped_sequence_insert (
    input  logic                       aclk,
    input  logic                       aresetn,

    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_kind,
    input  logic [gsi_pkg::POS_W-1:0]  s_position,
    input  logic [gsi_pkg::DATA_W-1:0] s_value,

    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [gsi_pkg::DATA_W-1:0] m_read_value,
    output logic                       m_read_used,
    output logic [gsi_pkg::LEN_W-1:0]  m_length,
    output logic                       m_full_res,

    input  logic                       cfg_wr_en,
    input  logic [gsi_pkg::LEN_W-1:0]  cfg_wr_data
);

    localparam int NPAD = gsi_pkg::NGROUPS * gsi_pkg::GROUP;

    // ---------------------------------------------------------------- sequencer
    gsi_pkg::gsi_state_t state_reg;
    gsi_pkg::gsi_state_t state_next;

    // item held for the duration of its work
    logic                           kind_reg;
    logic [gsi_pkg::IDX_W-1:0]      start_reg;
    logic                           in_range_reg;
    logic [gsi_pkg::VALUE_BITS-1:0] value_reg;

    // scan results
    logic                           found_reg;
    logic                           found_next;
    logic [gsi_pkg::IDX_W-1:0]      hole_reg;
    logic [gsi_pkg::IDX_W-1:0]      hole_next;
    logic                           rused_reg;
    logic                           rused_next;
    logic [gsi_pkg::VALUE_BITS-1:0] rdata_reg;
    logic [gsi_pkg::VALUE_BITS-1:0] rdata_next;

    logic [gsi_pkg::HM_W-1:0]       hm_reg;
    logic [gsi_pkg::HM_W-1:0]       hm_next;
    logic [gsi_pkg::LEN_W-1:0]      min_len_reg;

    // result register
    logic                           m_valid_reg;
    logic                           m_valid_next;
    logic [gsi_pkg::DATA_W-1:0]     rv_reg;
    logic [gsi_pkg::DATA_W-1:0]     rv_next;
    logic                           ru_reg;
    logic                           ru_next;
    logic [gsi_pkg::LEN_W-1:0]      len_reg;
    logic [gsi_pkg::LEN_W-1:0]      len_next;
    logic                           full_reg;
    logic                           full_next;

    logic                           accept;
    logic                           out_free;
    logic                           do_insert;
    logic                           load_out;
    logic                           in_range_in;
    logic [gsi_pkg::IDX_W-1:0]      start_in;
    logic [31:0]                    hole_len;
    logic [31:0]                    hm_max;

    gsi_pkg::gsi_shift_t            cmd;

    // ---------------------------------------------------------------- row
    logic [gsi_pkg::VALUE_BITS-1:0] cell_value [NPAD];
    logic [NPAD-1:0]                cell_used;
    gsi_pkg::gsi_grp_t              grp_sum [gsi_pkg::NGROUPS];

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    assign in_range_in = (s_position >= gsi_pkg::POS_W'(1)) &&
                         (32'(s_position) <= 32'(gsi_pkg::SLOTS));
    assign start_in    = gsi_pkg::IDX_W'(32'(s_position) - 32'd1);

    // insert really lands only with the position in range and a hole found
    assign do_insert = (state_reg == gsi_pkg::ST_APPLY) && out_free &&
                       (kind_reg == gsi_pkg::KIND_INSERT) && in_range_reg && found_reg;

    assign cmd.apply = do_insert;
    assign cmd.start = start_reg;
    assign cmd.hole  = hole_reg;
    assign cmd.value = value_reg;

    // Cells: each takes its left neighbor's slot on a shift; cell 0 sees an empty slot
    for (genvar i = 0; i < gsi_pkg::SLOTS; i++) begin : g_cell
        logic [gsi_pkg::VALUE_BITS-1:0] lv;
        logic                           lu;
        if (i == 0) begin : g_first
            assign lv = '0;
            assign lu = 1'b0;
        end else begin : g_rest
            assign lv = cell_value[i-1];
            assign lu = cell_used[i-1];
        end
        gsi_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .my_idx     (gsi_pkg::IDX_W'(i)),
            .cmd        (cmd),
            .left_value (lv),
            .left_used  (lu),
            .value_q    (cell_value[i]),
            .used_q     (cell_used[i])
        );
    end

    // Padding past the last slot reads as occupied so the search never lands there
    for (genvar i = gsi_pkg::SLOTS; i < NPAD; i++) begin : g_pad
        assign cell_value[i] = '0;
        assign cell_used[i]  = 1'b1;
    end

    for (genvar g = 0; g < gsi_pkg::NGROUPS; g++) begin : g_grp
        gsi_group u_group (
            .aclk    (aclk),
            .gnum    (gsi_pkg::GIDX_W'(g)),
            .start   (start_reg),
            .used    (cell_used[g*gsi_pkg::GROUP +: gsi_pkg::GROUP]),
            .value   (cell_value[g*gsi_pkg::GROUP +: gsi_pkg::GROUP]),
            .summary (grp_sum[g])
        );
    end

    // Scan across group summaries: lowest group with a hole wins; read data is one-hot
    always_comb begin
        found_next = 1'b0;
        hole_next  = '0;
        rused_next = 1'b0;
        rdata_next = '0;
        for (int g = gsi_pkg::NGROUPS - 1; g >= 0; g--) begin
            if (grp_sum[g].found) begin
                found_next = 1'b1;
                hole_next  = gsi_pkg::IDX_W'((32'(g) << gsi_pkg::LIDX_W) +
                                             32'(grp_sum[g].first));
            end
        end
        for (int g = 0; g < gsi_pkg::NGROUPS; g++) begin
            rused_next = rused_next | grp_sum[g].rused;
            rdata_next = rdata_next | grp_sum[g].rdata;
        end
    end

    // High mark after this item, and the length reported with it
    assign hole_len = 32'(hole_reg) + 32'd1;
    always_comb begin
        hm_next = hm_reg;
        if (do_insert && (hole_len > 32'(hm_reg))) begin
            hm_next = gsi_pkg::HM_W'(hole_len);
        end
    end
    assign hm_max = (32'(hm_next) > 32'(min_len_reg)) ? 32'(hm_next) : 32'(min_len_reg);

    // ---------------------------------------------------------------- next state and outputs
    always_comb begin
        state_next   = state_reg;
        load_out     = 1'b0;
        case (state_reg)
            gsi_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = gsi_pkg::ST_GROUP;
                end
            end
            gsi_pkg::ST_GROUP: begin
                state_next = gsi_pkg::ST_SCAN;
            end
            gsi_pkg::ST_SCAN: begin
                state_next = gsi_pkg::ST_APPLY;
            end
            gsi_pkg::ST_APPLY: begin
                // hold until the result register frees up
                if (out_free) begin
                    load_out   = 1'b1;
                    state_next = gsi_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = gsi_pkg::ST_IDLE;
            end
        endcase
    end

    assign s_ready = (state_reg == gsi_pkg::ST_IDLE);

    always_comb begin
        m_valid_next = m_valid_reg;
        rv_next      = rv_reg;
        ru_next      = ru_reg;
        len_next     = len_reg;
        full_next    = full_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (load_out) begin
            m_valid_next = 1'b1;
            len_next     = gsi_pkg::LEN_W'(hm_max);
            if (kind_reg == gsi_pkg::KIND_READ) begin
                ru_next   = in_range_reg && rused_reg;
                rv_next   = (in_range_reg && rused_reg) ? gsi_pkg::DATA_W'(rdata_reg) : '0;
                full_next = 1'b0;
            end else begin
                ru_next   = 1'b0;
                rv_next   = '0;
                // drop an insert with no hole or a position off the row
                full_next = !(in_range_reg && found_reg);
            end
        end
    end

    // ---------------------------------------------------------------- registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= gsi_pkg::ST_IDLE;
            hm_reg      <= '0;
            min_len_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            hm_reg      <= hm_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                min_len_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            kind_reg     <= s_kind;
            start_reg    <= start_in;
            in_range_reg <= in_range_in;
            value_reg    <= gsi_pkg::VALUE_BITS'(s_value);
        end
        if (state_reg == gsi_pkg::ST_SCAN) begin
            found_reg <= found_next;
            hole_reg  <= hole_next;
            rused_reg <= rused_next;
            rdata_reg <= rdata_next;
        end
        rv_reg   <= rv_next;
        ru_reg   <= ru_next;
        len_reg  <= len_next;
        full_reg <= full_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_read_value = rv_reg;
    assign m_read_used  = ru_reg;
    assign m_length     = len_reg;
    assign m_full_res   = full_reg;

endmodule

// ===== tb/sv/gapped_sequence_insert_test.sv =====
// Self-checking testbench for gapped_sequence_insert: directed and random insert/read items,
// each result compared against an in-bench slot row predictor. Depends on gsi_pkg and the RTL.
module gapped_sequence_insert_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROW           = gsi_pkg::SLOTS;
    localparam int POS_W         = gsi_pkg::POS_W;
    localparam int DATA_W        = gsi_pkg::DATA_W;
    localparam int LEN_W         = gsi_pkg::LEN_W;
    localparam int POS_MAX       = (1 << POS_W) - 1;
    // Long enough for the result register and the item in work to back up the input
    localparam int HOLD_OFF_LEN  = 200;
    localparam int SETTLE_CYCLES = 20;

    typedef struct packed {
        logic [DATA_W-1:0] read_value;
        logic              read_used;
        logic [LEN_W-1:0]  length;
        logic              full_res;
    } slot_result_t;

    logic              aclk;
    logic              aresetn      = 1'b0;
    logic              s_valid      = 1'b0;
    logic              s_ready;
    logic              s_kind       = gsi_pkg::KIND_READ;
    logic [POS_W-1:0]  s_position   = '0;
    logic [DATA_W-1:0] s_value      = '0;
    logic              m_valid;
    logic              m_ready      = 1'b0;
    logic [DATA_W-1:0] m_read_value;
    logic              m_read_used;
    logic [LEN_W-1:0]  m_length;
    logic              m_full_res;
    logic              cfg_wr_en    = 1'b0;
    logic [LEN_W-1:0]  cfg_wr_data  = '0;

    // Predicted row contents, high mark and length floor
    logic [gsi_pkg::VALUE_BITS-1:0] slot_val [ROW];
    bit                             slot_busy [ROW];
    int unsigned                    top_mark;
    logic [LEN_W-1:0]               len_floor;

    slot_result_t expected_slot_results [$];
    int unsigned  mismatch_count = 0;
    bit           sender_gaps    = 1'b1;
    bit           sink_gaps      = 1'b1;
    bit           hold_off_req   = 1'b0;

    gapped_sequence_insert uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_kind       (s_kind),
        .s_position   (s_position),
        .s_value      (s_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_read_value (m_read_value),
        .m_read_used  (m_read_used),
        .m_length     (m_length),
        .m_full_res   (m_full_res),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Hard stop in case the block hangs or drops a result
    initial begin
        #2_000_000;
        $display("gapped_sequence_insert verification failed");
        $finish;
    end

    // Apply one item to the predicted row and return the result it should produce.
    // An insert walks right from the position to the first free slot, slides the run
    // in between one place right and drops the value into the opened slot.
    function automatic slot_result_t predict_slot_result(logic kind, logic [POS_W-1:0] pos,
                                                         logic [DATA_W-1:0] val);
        slot_result_t res;
        bit           in_row;
        int           start;
        int           hole;
        res    = '0;
        in_row = (pos >= 1) && (pos <= ROW);
        if (kind == gsi_pkg::KIND_READ) begin
            if (in_row && slot_busy[pos - 1]) begin
                res.read_used  = 1'b1;
                res.read_value = DATA_W'(slot_val[pos - 1]);
            end
        end else if (!in_row) begin
            // Position zero or past the row end: drop the insert
            res.full_res = 1'b1;
        end else begin
            start = pos - 1;
            hole  = start;
            while (hole < ROW && slot_busy[hole])
                hole++;
            if (hole == ROW) begin
                // No free slot at or after the position: drop, leave the row alone
                res.full_res = 1'b1;
            end else begin
                for (int i = hole; i > start; i--) begin
                    slot_val[i]  = slot_val[i - 1];
                    slot_busy[i] = slot_busy[i - 1];
                end
                slot_val[start]  = val;
                slot_busy[start] = 1'b1;
                if (hole + 1 > top_mark)
                    top_mark = hole + 1;
            end
        end
        res.length = (top_mark > len_floor) ? LEN_W'(top_mark) : len_floor;
        return res;
    endfunction

    // Offer one item, optionally after a short idle burst, and hold it until accepted.
    // Valid stays high on return so a back-to-back item needs no second assignment.
    task automatic offer_item(logic kind, logic [POS_W-1:0] pos, logic [DATA_W-1:0] val);
        int unsigned gap;
        gap = (sender_gaps && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_kind     <= kind;
        s_position <= pos;
        s_value    <= val;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        expected_slot_results.push_back(predict_slot_result(kind, pos, val));
    endtask

    // Random item: mostly in-row positions up to pos_hi, a few out-of-row ones as noise
    task automatic offer_random_item(int unsigned insert_pct, int unsigned pos_hi);
        logic             kind;
        logic [POS_W-1:0] pos;
        kind = ($urandom_range(0, 99) < insert_pct) ? gsi_pkg::KIND_INSERT
                                                     : gsi_pkg::KIND_READ;
        if ($urandom_range(0, 19) == 0)
            pos = ($urandom_range(0, 3) == 0) ? '0 : POS_W'($urandom_range(ROW + 1, POS_MAX));
        else
            pos = POS_W'($urandom_range(1, pos_hi));
        offer_item(kind, pos, DATA_W'($urandom));
    endtask

    // Drop valid and hold until every predicted result has come back
    task automatic wait_drained();
        s_valid <= 1'b0;
        do
            @(posedge aclk);
        while (expected_slot_results.size() != 0);
    endtask

    // Only called with the block idle
    task automatic set_min_length(logic [LEN_W-1:0] len);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= len;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        len_floor    = len;
        @(posedge aclk);
    endtask

    // Receiver: random short stalls, or one long hold-off on request
    initial begin : result_sink
        int unsigned stall_left;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                stall_left   = HOLD_OFF_LEN;
            end else if (stall_left == 0 && sink_gaps && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 3);
            end
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0h got %0h", $time, field, want, got);
            mismatch_count++;
        end
    endfunction

    // Compare each accepted result with the oldest prediction
    always @(posedge aclk) begin : result_check
        slot_result_t want;
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            if (expected_slot_results.size() == 0) begin
                $display("%0t: unexpected result value %0h used %0b length %0d full %0b",
                         $time, m_read_value, m_read_used, m_length, m_full_res);
                mismatch_count++;
            end else begin
                want = expected_slot_results.pop_front();
                check_field("read_value", 32'(want.read_value), 32'(m_read_value));
                check_field("read_used", 32'(want.read_used), 32'(m_read_used));
                check_field("length", 32'(want.length), 32'(m_length));
                check_field("full_res", 32'(want.full_res), 32'(m_full_res));
            end
        end
    end

    // Empty row, length floor at its top: positions 0, ROW + 1, POS_MAX, reads of free slots
    task automatic test_out_of_range();
        set_min_length(LEN_W'(ROW));
        offer_item(gsi_pkg::KIND_READ, POS_W'(1), 16'h0000);
        offer_item(gsi_pkg::KIND_READ, POS_W'(ROW), 16'hFFFF);
        offer_item(gsi_pkg::KIND_READ, '0, 16'hFFFF);
        offer_item(gsi_pkg::KIND_READ, POS_W'(POS_MAX), 16'h0000);
        offer_item(gsi_pkg::KIND_INSERT, '0, 16'hFFFF);
        offer_item(gsi_pkg::KIND_INSERT, POS_W'(POS_MAX), 16'hFFFF);
        offer_item(gsi_pkg::KIND_INSERT, POS_W'(ROW + 1), 16'h0001);
        wait_drained();
    endtask

    // Small hand-built shifts at the front of the row, length floor at zero
    task automatic test_front_shift();
        set_min_length('0);
        offer_item(gsi_pkg::KIND_INSERT, POS_W'(1), 16'h0000);
        offer_item(gsi_pkg::KIND_READ, POS_W'(1), 16'hFFFF);   // used slot holding zero
        offer_item(gsi_pkg::KIND_READ, POS_W'(2), 16'h0000);   // free slot
        offer_item(gsi_pkg::KIND_INSERT, POS_W'(1), 16'hFFFF); // push slot 1 into slot 2
        offer_item(gsi_pkg::KIND_READ, POS_W'(1), 16'h0000);
        offer_item(gsi_pkg::KIND_READ, POS_W'(2), 16'h0000);
        offer_item(gsi_pkg::KIND_INSERT, POS_W'(3), 16'h8001); // lands in a hole, no shift
        offer_item(gsi_pkg::KIND_INSERT, POS_W'(2), 16'h1234); // slide two slots right
        offer_item(gsi_pkg::KIND_READ, POS_W'(2), 16'h0000);
        offer_item(gsi_pkg::KIND_READ, POS_W'(3), 16'h0000);
        offer_item(gsi_pkg::KIND_READ, POS_W'(4), 16'h0000);
        offer_item(gsi_pkg::KIND_INSERT, POS_W'(1), 16'h5A5A); // slide the whole run
        offer_item(gsi_pkg::KIND_READ, POS_W'(5), 16'h0000);
        offer_item(gsi_pkg::KIND_READ, POS_W'(1), 16'h0000);
        wait_drained();
    endtask

    // Dense inserts in a narrow window build long runs and long shifts.
    // Midway, stall the receiver so the block backs up, then pause the sender.
    task automatic test_dense_front();
        set_min_length(LEN_W'(20));
        for (int n = 0; n < 300; n++) begin
            if (n == 100)
                hold_off_req = 1'b1;
            if (n == 200)
                wait_drained();
            offer_random_item(70, 48);
        end
        wait_drained();
    endtask

    // Inserts and reads spread over the whole row
    task automatic test_wide_spread();
        set_min_length(LEN_W'($urandom_range(64, 1000)));
        for (int n = 0; n < 600; n++)
            offer_random_item(60, ROW);
        wait_drained();
    endtask

    // Last slot: fill it, then an insert there finds no hole
    task automatic test_row_end();
        set_min_length(LEN_W'(ROW - 1));
        sink_gaps   = 1'b0;
        sender_gaps = 1'b0;
        offer_item(gsi_pkg::KIND_INSERT, POS_W'(ROW), 16'hFFFF);
        offer_item(gsi_pkg::KIND_INSERT, POS_W'(ROW), 16'h0001);
        offer_item(gsi_pkg::KIND_READ, POS_W'(ROW), 16'h0000);
        offer_item(gsi_pkg::KIND_READ, POS_W'(ROW - 1), 16'h0000);
        wait_drained();
    endtask

    // Heavy inserts until most of the row is full and drops dominate; no idling
    task automatic test_fill_up();
        for (int n = 0; n < 750; n++)
            offer_random_item(80, ROW);
    endtask

    initial begin : run_tests
        for (int i = 0; i < ROW; i++) begin
            slot_val[i]  = '0;
            slot_busy[i] = 1'b0;
        end
        top_mark  = 0;
        len_floor = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_out_of_range();
        test_front_shift();
        test_dense_front();
        test_wide_spread();
        test_row_end();
        test_fill_up();

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatch_count == 0)
            $display("gapped_sequence_insert verification clean");
        else
            $display("gapped_sequence_insert verification failed");
        $finish;
    end

endmodule
